// ===== rtl/core/rbrf_pkg.sv =====
// Shared constants and types for the relative bearing / range / field-of-view unit.
// Holds the fixed-point formats, the CORDIC arctangent table and the gain constant.
// No dependencies.
package rbrf_pkg;

    localparam int POS_BITS     = 24;   // width of each position input, 8 fractional bits
    localparam int CORDIC_STEPS = 16;   // number of vectoring iterations, 8 to 24
    localparam int GUARD        = 8;    // extra fraction bits carried through the iterations
    localparam int TABLE_LEN    = 24;

    localparam int DIFF_W  = POS_BITS + 1;             // observer-to-target offset
    localparam int XY_W    = POS_BITS + GUARD + 4;     // CORDIC datapath, covers gain growth
    localparam int UX_W    = XY_W - 1;                 // non-negative x magnitude
    localparam int PROD_W  = UX_W + 16;                // x times one half of the gain
    localparam int SUM_W   = PROD_W + 1;
    localparam int RANGE_W = 25;
    localparam int RQ_RAW  = SUM_W - GUARD - 16;
    localparam int RQ_W    = (RQ_RAW > RANGE_W + 1) ? RQ_RAW : RANGE_W + 1;
    localparam int ANG_W   = 16;
    localparam int HFOV_W  = 15;
    localparam int LATENCY = CORDIC_STEPS + 5;

    localparam logic [15:0]       GAIN_HI      = 16'h9B74;
    localparam logic [15:0]       GAIN_LO      = 16'hEDA8;
    localparam logic [HFOV_W-1:0] HALF_FOV_RST = 15'd5461;
    localparam logic [31:0]       HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0]       ANG_RND      = 32'h0000_8000;

    typedef logic [ANG_W-1:0] t_angle;

    localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ===== rtl/core/relative_bearing_range_fov_unit.sv =====
// Top level of the relative bearing / range / field-of-view unit.
// Pipelined vectoring CORDIC with gain compensation; depends on rbrf_pkg.
// One module holds the whole datapath.

// Usage: drive the target and observer positions and the observer heading with start high
// for one cycle per query. busy is always low, so a new word may enter on every clock and
// the unit sustains one query per cycle. Each query comes back with o_valid high for one
// cycle; the pipeline depth is set by one register stage per CORDIC iteration plus offset,
// setup, two gain-multiply stages and the output stage. There is no backpressure: the
// receiver must take each result word on the cycle it appears. Write the half field of view
// through i_cfg_we / i_cfg_wdata while no query is in flight; it resets to 5461 (30 degrees).
// A target on top of the observer gives range 0 and an absolute angle of 0.
module relative_bearing_range_fov_unit
    import rbrf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [POS_BITS-1:0] i_target_x,
    input  logic signed [POS_BITS-1:0] i_target_y,
    input  logic signed [POS_BITS-1:0] i_observer_x,
    input  logic signed [POS_BITS-1:0] i_observer_y,
    input  logic [ANG_W-1:0]           i_observer_angle,
    input  logic                       i_cfg_we,
    input  logic [HFOV_W-1:0]          i_cfg_wdata,
    output logic                       o_valid,
    output logic [RANGE_W-1:0]         o_range_out,
    output logic signed [ANG_W-1:0]    o_bearing,
    output logic                       o_in_view
);

    localparam logic [SUM_W:0] RND_ONE = (SUM_W+1)'(1) << (GUARD + 15);

    // Configuration register
    logic [HFOV_W-1:0] r_half_fov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_fov <= HALF_FOV_RST;
        end else if (i_cfg_we) begin
            r_half_fov <= i_cfg_wdata;
        end
    end

    // Every cycle can take a word.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------------------
    // Stage 1: form the observer-to-target offset.
    // ---------------------------------------------------------------------------------
    logic                     r_p1_v;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    t_angle                   r_p1_obs;
    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;

    assign n_dx = DIFF_W'(i_target_x) - DIFF_W'(i_observer_x);
    assign n_dy = DIFF_W'(i_target_y) - DIFF_W'(i_observer_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_p1_obs <= i_observer_angle;
    end

    // ---------------------------------------------------------------------------------
    // Stage 2: fold the left half plane onto the right by a half turn, add guard bits.
    // Index 0 of the CORDIC arrays is this stage's output.
    // ---------------------------------------------------------------------------------
    logic                    r_v    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_x    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  r_y    [0:CORDIC_STEPS];
    logic [31:0]             r_z    [0:CORDIC_STEPS];
    t_angle                  r_obs  [0:CORDIC_STEPS];
    logic                    r_zero [0:CORDIC_STEPS];

    logic                     w_neg;
    logic signed [DIFF_W-1:0] w_ax;
    logic signed [DIFF_W-1:0] w_ay;

    assign w_neg = r_dx[DIFF_W-1];
    assign w_ax  = w_neg ? -r_dx : r_dx;
    assign w_ay  = w_neg ? -r_dy : r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= XY_W'(w_ax) <<< GUARD;
        r_y[0]    <= XY_W'(w_ay) <<< GUARD;
        r_z[0]    <= w_neg ? HALF_TURN : 32'h0;
        r_obs[0]  <= r_p1_obs;
        r_zero[0] <= (r_dx == '0) && (r_dy == '0);
    end

    // ---------------------------------------------------------------------------------
    // CORDIC iterations, one register stage each: rotate toward y = 0.
    // ---------------------------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [XY_W-1:0] w_xs;
        logic signed [XY_W-1:0] w_ys;
        logic                   w_up;
        logic signed [XY_W-1:0] n_x;
        logic signed [XY_W-1:0] n_y;
        logic [31:0]            n_z;

        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        assign w_up = !r_y[i][XY_W-1] && (r_y[i] != '0);

        always_comb begin
            if (w_up) begin
                n_x = r_x[i] + w_ys;
                n_y = r_y[i] - w_xs;
                n_z = r_z[i] + ATAN_TAB[i];
            end else begin
                n_x = r_x[i] - w_ys;
                n_y = r_y[i] + w_xs;
                n_z = r_z[i] - ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1]    <= n_x;
            r_y[i+1]    <= n_y;
            r_z[i+1]    <= n_z;
            r_obs[i+1]  <= r_obs[i];
            r_zero[i+1] <= r_zero[i];
        end
    end

    // ---------------------------------------------------------------------------------
    // Stage 3: split gain multiply; round the absolute angle and subtract the heading.
    // ---------------------------------------------------------------------------------
    logic               r_p3_v;
    logic [PROD_W-1:0]  r_hi;
    logic [PROD_W-1:0]  r_lo;
    t_angle             r_p3_rel;
    logic               r_p3_zero;
    logic [UX_W-1:0]    w_ux;
    logic [31:0]        w_zr;
    t_angle             w_abs;

    assign w_ux  = r_x[CORDIC_STEPS][XY_W-1] ? '0 : r_x[CORDIC_STEPS][UX_W-1:0];
    assign w_zr  = r_z[CORDIC_STEPS] + ANG_RND;
    // Coincident points: take the absolute angle as zero.
    assign w_abs = r_zero[CORDIC_STEPS] ? '0 : w_zr[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi      <= PROD_W'(w_ux) * PROD_W'(GAIN_HI);
        r_lo      <= PROD_W'(w_ux) * PROD_W'(GAIN_LO);
        r_p3_rel  <= w_abs - r_obs[CORDIC_STEPS];
        r_p3_zero <= r_zero[CORDIC_STEPS];
    end

    // ---------------------------------------------------------------------------------
    // Stage 4: merge the partial products, dropping the low 16 bits of the lower one.
    // ---------------------------------------------------------------------------------
    logic              r_p4_v;
    logic [SUM_W-1:0]  r_sum;
    t_angle            r_p4_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= r_p3_zero ? '0 : (SUM_W'(r_hi) + SUM_W'(r_lo >> 16));
        r_p4_rel <= r_p3_rel;
    end

    // ---------------------------------------------------------------------------------
    // Output stage: round and saturate the range, test the bearing against the window.
    // ---------------------------------------------------------------------------------
    logic [SUM_W:0]         w_rnd;
    logic [RQ_W-1:0]        w_q;
    logic [RANGE_W-1:0]     w_range;
    logic signed [ANG_W:0]  w_b;
    logic signed [ANG_W:0]  w_hf;
    logic                   r_o_v;
    logic [RANGE_W-1:0]     r_range;
    t_angle                 r_bearing;
    logic                   r_in_view;

    assign w_rnd   = {1'b0, r_sum} + RND_ONE;
    assign w_q     = RQ_W'(w_rnd >> (GUARD + 16));
    assign w_range = (|w_q[RQ_W-1:RANGE_W]) ? '1 : w_q[RANGE_W-1:0];
    assign w_b     = signed'({r_p4_rel[ANG_W-1], r_p4_rel});
    assign w_hf    = signed'({2'b00, r_half_fov});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_p4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range   <= w_range;
        r_bearing <= r_p4_rel;
        r_in_view <= (w_b <= w_hf) && (w_b >= -w_hf);
    end

    assign o_valid     = r_o_v;
    assign o_range_out = r_range;
    assign o_bearing   = signed'(r_bearing);
    assign o_in_view   = r_in_view;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("result word missing at fixed latency");

    a_x_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[CORDIC_STEPS] |-> !r_x[CORDIC_STEPS][XY_W-1])
        else $error("CORDIC x went negative, datapath overflow");

    a_half_turn_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bearing == 16'sh8000) |-> !o_in_view)
        else $error("bearing at minus half turn flagged in view");

    a_zero_range_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3_v && r_p3_zero) |=> (r_sum == '0))
        else $error("coincident points gave nonzero range sum");

endmodule
